FILE: hdl/adam_parameter_update_assert.svh
// Assertion macros for the Adam parameter update block
`ifndef ADAM_PARAMETER_UPDATE_ASSERT_SVH
`define ADAM_PARAMETER_UPDATE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check that cons holds in the same cycle as ante
`define APU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adam_parameter_update: assertion failed");
// Check that cons holds in the cycle after ante
`define APU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adam_parameter_update: assertion failed");
`else
`define APU_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define APU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/apu_pkg.sv
// Shared types and constants for the Adam parameter update block
package apu_pkg;

    localparam int NUM_PARAMS_DEF = 1024;
    localparam int IDX_W = 10;
    localparam int VAL_W = 32;
    localparam int CFG_W = 24;
    localparam int APB_AW = 4;
    localparam int DIV_NUM_W = 80;
    localparam int DIV_DEN_W = 42;

    localparam logic [CFG_W-1:0] STEP_SIZE_RST    = 24'd16777;
    localparam logic [CFG_W-1:0] FIRST_DECAY_RST  = 24'd15099494;
    localparam logic [CFG_W-1:0] SECOND_DECAY_RST = 24'd16760438;
    localparam logic [CFG_W-1:0] STABILIZER_RST   = 24'd1;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_STEP_SIZE    = 2'd0;
    localparam logic [1:0] REG_FIRST_DECAY  = 2'd1;
    localparam logic [1:0] REG_SECOND_DECAY = 2'd2;
    localparam logic [1:0] REG_STABILIZER   = 2'd3;

    typedef struct packed {
        logic [CFG_W-1:0] step_size;
        logic [CFG_W-1:0] first_decay;
        logic [CFG_W-1:0] second_decay;
        logic [CFG_W-1:0] stabilizer;
    } cfg_t;

    typedef enum logic [3:0] {
        MS_M1, MS_M2, MS_G2, MS_V1, MS_V2, MS_PL, MS_PH, MS_P1, MS_P2
    } mul_sel_t;

    typedef enum logic [1:0] {
        DL_NONE, DL_MHAT, DL_VHAT, DL_UPD
    } div_load_t;

    typedef struct packed {
        logic      capture;
        logic      red_step;
        logic [3:0] red_shift;
        logic      mem_read;
        logic      mem_write;
        logic      clr_write;
        mul_sel_t  mul_sel;
        logic      acc_load;
        logic      m_update;
        logic      g2_update;
        logic      v_update;
        div_load_t div_load;
        logic      div_step;
        logic      mhat_load;
        logic      sqrt_load;
        logic      sqrt_step;
        logic      den_load;
        logic      plo_load;
        logic      out_load;
        logic      p1_update;
        logic      p2_update;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic upd_cap;
        logic eos;
    } status_t;

endpackage

FILE: hdl/apu_param_if.sv
// Input channel carrying one parameter per transaction
interface apu_param_if;
    import apu_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        param_index;
    logic signed [VAL_W-1:0] gradient_value;
    logic signed [VAL_W-1:0] current_value;
    logic                    end_of_step;

    modport source (output valid, param_index, gradient_value, current_value, end_of_step,
                    input ready);
    modport sink (input valid, param_index, gradient_value, current_value, end_of_step,
                  output ready);
endinterface

FILE: hdl/apu_result_if.sv
// Output channel carrying one updated parameter per transaction
interface apu_result_if;
    import apu_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        index_out;
    logic signed [VAL_W-1:0] updated_value;
    logic                    step_done;

    modport source (output valid, index_out, updated_value, step_done, input ready);
    modport sink (input valid, index_out, updated_value, step_done, output ready);
endinterface

FILE: hdl/apu_div.sv
// Restoring divider, one quotient bit per cycle while step is high
module apu_div
    import apu_pkg::*;
(
    input  logic                 clk,
    input  logic                 load,
    input  logic                 step,
    input  logic [DIV_DEN_W-1:0] rem_init,
    input  logic [DIV_NUM_W-1:0] num_init,
    input  logic [DIV_DEN_W-1:0] den_init,
    output logic [DIV_NUM_W-1:0] quot
);

    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W:0]   part;
    logic [DIV_DEN_W:0]   diff;
    logic                 qbit;

    // Trial subtract of the shifted remainder
    always_comb
    begin
        part     = {rem_reg, num_reg[DIV_NUM_W-1]};
        diff     = part - {1'b0, den_reg};
        qbit     = ~diff[DIV_DEN_W];
        rem_next = qbit ? diff[DIV_DEN_W-1:0] : part[DIV_DEN_W-1:0];
        num_next = {num_reg[DIV_NUM_W-2:0], qbit};
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= rem_init;
            num_reg <= num_init;
            den_reg <= den_init;
        end
        else if (step)
        begin
            rem_reg <= rem_next;
            num_reg <= num_next;
        end
    end

    assign quot = num_reg;

endmodule

FILE: hdl/apu_dp.sv
// Datapath: moment stores, shared multiplier, divider, square root, output register
module apu_dp
    import apu_pkg::*;
#(
    parameter int NUM_PARAMS = NUM_PARAMS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    p1_reload,
    input  logic                    p2_reload,
    input  logic [CFG_W-1:0]        reload_value,
    input  cmd_t                    cmd,
    output status_t                 status,
    input  logic [IDX_W-1:0]        param_index,
    input  logic signed [VAL_W-1:0] gradient_value,
    input  logic signed [VAL_W-1:0] current_value,
    input  logic                    end_of_step,
    output logic [IDX_W-1:0]        index_out,
    output logic signed [VAL_W-1:0] updated_value,
    output logic                    step_done
);

    localparam int AW = $clog2(NUM_PARAMS);
    localparam int RED_W = IDX_W + 17;
    localparam logic [24:0] ONE_Q24 = 25'h1000000;
    localparam logic [65:0] HALF_Q24 = 66'h800000;
    localparam logic [40:0] UPD_CAP = 41'h100_0000_0000;
    localparam logic signed [42:0] RES_MAX = 43'sd2147483647;
    localparam logic signed [42:0] RES_MIN = -43'sd2147483648;

    // Captured item
    logic [IDX_W-1:0]        idx_reg;
    logic signed [VAL_W-1:0] g_reg;
    logic signed [VAL_W-1:0] cur_reg;
    logic                    eos_reg;
    logic [IDX_W-1:0]        red_reg;

    // Moment stores
    logic signed [31:0] m_mem [NUM_PARAMS];
    logic [31:0]        v_mem [NUM_PARAMS];
    logic signed [31:0] m_rd_reg;
    logic [31:0]        v_rd_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic [AW-1:0]      slot;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_m;
    logic [31:0]        wr_v;
    logic               mem_we;

    // Arithmetic
    logic signed [32:0] mul_a, mul_b;
    logic signed [32:0] g_ext, g_mag;
    logic [24:0]        omb1, omb2, d1, d2;
    logic signed [65:0] prod_reg, acc_reg, sum;
    logic [65:0]        sum_mag, rnd_full, g2_full, pw_full;
    logic [41:0]        rnd;
    logic [41:0]        g2_rnd;
    logic signed [31:0] m_new, m_new_reg;
    logic [31:0]        v_new, v_new_reg, g2_reg;
    logic [31:0]        m_mag;
    logic [55:0]        mhat_reg, plo_reg;
    logic [CFG_W-1:0]   p1_reg, p2_reg;
    logic [RED_W-1:0]   mod_k;

    // Divider
    logic [DIV_DEN_W-1:0] div_rem_init, div_den_init, den_reg;
    logic [DIV_NUM_W-1:0] div_num_init, quot, p_full;
    logic                 div_load;
    logic                 cap_reg;

    // Square root
    logic [63:0] sx_reg;
    logic [34:0] srem_reg, r2, trial;
    logic [31:0] sroot_reg;
    logic        sshift_reg;
    logic        small_rad;
    logic [39:0] root40;
    logic [DIV_DEN_W-1:0] den_sum;

    // Final update
    logic [40:0]        upd;
    logic signed [42:0] cur_ext, upd_ext, res;
    logic signed [31:0] res_sat;

    // Capture the item and reduce its index to a store slot
    always_comb
    begin
        mod_k = RED_W'(NUM_PARAMS) << cmd.red_shift;
        slot  = AW'(red_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            idx_reg <= param_index;
            g_reg   <= gradient_value;
            cur_reg <= current_value;
            eos_reg <= end_of_step;
            red_reg <= param_index;
        end
        else if (cmd.red_step && ({17'b0, red_reg} >= mod_k))
        begin
            red_reg <= red_reg - mod_k[IDX_W-1:0];
        end
    end

    // Sweep the stores after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_write)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // Store write and registered read
    always_comb
    begin
        mem_we  = cmd.clr_write | cmd.mem_write;
        wr_addr = cmd.clr_write ? clr_addr_reg : slot;
        wr_m    = cmd.clr_write ? 32'(STABILIZER_RST) : m_new_reg;
        wr_v    = cmd.clr_write ? 32'(STABILIZER_RST) : v_new;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            m_mem[wr_addr] <= wr_m;
            v_mem[wr_addr] <= wr_v;
        end
        if (cmd.mem_read)
        begin
            m_rd_reg <= m_mem[slot];
            v_rd_reg <= v_mem[slot];
        end
    end

    // Multiplier operand select
    always_comb
    begin
        g_ext = {g_reg[31], g_reg};
        g_mag = g_reg[31] ? -g_ext : g_ext;
        omb1  = ONE_Q24 - {1'b0, cfg.first_decay};
        omb2  = ONE_Q24 - {1'b0, cfg.second_decay};
        d1    = ONE_Q24 - {1'b0, p1_reg};
        d2    = ONE_Q24 - {1'b0, p2_reg};
        case (cmd.mul_sel)
            MS_M1:
            begin
                mul_a = {9'b0, cfg.first_decay};
                mul_b = {m_rd_reg[31], m_rd_reg};
            end
            MS_M2:
            begin
                mul_a = {8'b0, omb1};
                mul_b = g_ext;
            end
            MS_G2:
            begin
                mul_a = g_mag;
                mul_b = g_mag;
            end
            MS_V1:
            begin
                mul_a = {9'b0, cfg.second_decay};
                mul_b = {1'b0, v_rd_reg};
            end
            MS_V2:
            begin
                mul_a = {8'b0, omb2};
                mul_b = {1'b0, g2_reg};
            end
            MS_PL:
            begin
                mul_a = {1'b0, mhat_reg[31:0]};
                mul_b = {9'b0, cfg.step_size};
            end
            MS_PH:
            begin
                mul_a = {9'b0, mhat_reg[55:32]};
                mul_b = {9'b0, cfg.step_size};
            end
            MS_P1:
            begin
                mul_a = {9'b0, p1_reg};
                mul_b = {9'b0, cfg.first_decay};
            end
            MS_P2:
            begin
                mul_a = {9'b0, p2_reg};
                mul_b = {9'b0, cfg.second_decay};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Round and saturate the moment sums
    always_comb
    begin
        sum      = acc_reg + prod_reg;
        sum_mag  = sum[65] ? 66'(-sum) : 66'(sum);
        rnd_full = sum_mag + HALF_Q24;
        rnd      = rnd_full[65:24];
        if (sum[65])
            m_new = (rnd > 42'h80000000) ? 32'sh80000000 : -$signed(rnd[31:0]);
        else
            m_new = (rnd > 42'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(rnd[31:0]);
        v_new    = (rnd[41:32] != '0) ? 32'hFFFFFFFF : rnd[31:0];
        g2_full  = 66'(prod_reg) + HALF_Q24;
        g2_rnd   = g2_full[65:24];
        pw_full  = 66'(prod_reg) + HALF_Q24;
        m_mag    = m_new_reg[31] ? 32'(-m_new_reg) : 32'(m_new_reg);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd.acc_load)
            acc_reg <= prod_reg;
        if (cmd.m_update)
            m_new_reg <= m_new;
        if (cmd.g2_update)
            g2_reg <= (g2_rnd[41:32] != '0) ? 32'hFFFFFFFF : g2_rnd[31:0];
        if (cmd.v_update)
            v_new_reg <= v_new;
        if (cmd.mhat_load)
            mhat_reg <= quot[55:0];
        if (cmd.plo_load)
            plo_reg <= prod_reg[55:0];
    end

    // Decay powers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg <= FIRST_DECAY_RST;
            p2_reg <= SECOND_DECAY_RST;
        end
        else
        begin
            if (p1_reload)
                p1_reg <= reload_value;
            else if (cmd.p1_update)
                p1_reg <= pw_full[47:24];
            if (p2_reload)
                p2_reg <= reload_value;
            else if (cmd.p2_update)
                p2_reg <= pw_full[47:24];
        end
    end

    // Divider loads: bias corrections and the final update
    always_comb
    begin
        p_full       = {prod_reg[47:0], 32'b0} + {24'b0, plo_reg};
        div_load     = (cmd.div_load != DL_NONE);
        div_rem_init = '0;
        div_num_init = '0;
        div_den_init = '0;
        case (cmd.div_load)
            DL_MHAT:
            begin
                div_num_init = {m_mag, 48'b0};
                div_den_init = DIV_DEN_W'(d1);
            end
            DL_VHAT:
            begin
                div_num_init = {v_new_reg, 48'b0};
                div_den_init = DIV_DEN_W'(d2);
            end
            DL_UPD:
            begin
                div_rem_init = DIV_DEN_W'(p_full[79:41]);
                div_num_init = {p_full[40:0], 39'b0};
                div_den_init = den_reg;
            end
            default:
            begin
                div_num_init = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load == DL_UPD)
            cap_reg <= (DIV_DEN_W'(p_full[79:41]) >= den_reg);
    end

    apu_div u_div (
        .clk      (clk),
        .load     (div_load),
        .step     (cmd.div_step),
        .rem_init (div_rem_init),
        .num_init (div_num_init),
        .den_init (div_den_init),
        .quot     (quot)
    );

    // Square root, two radicand bits per cycle while sqrt_step is high
    always_comb
    begin
        small_rad = (quot[55:40] == '0);
        r2        = {srem_reg[32:0], sx_reg[63:62]};
        trial     = {1'b0, sroot_reg, 2'b01};
        root40    = sshift_reg ? {sroot_reg, 8'b0} : {8'b0, sroot_reg};
        den_sum   = DIV_DEN_W'(root40) + DIV_DEN_W'(cfg.stabilizer);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_load)
        begin
            sx_reg     <= small_rad ? {quot[39:0], 24'b0} : {quot[55:0], 8'b0};
            sshift_reg <= ~small_rad;
            srem_reg   <= '0;
            sroot_reg  <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            sx_reg <= {sx_reg[61:0], 2'b00};
            if (r2 >= trial)
            begin
                srem_reg  <= r2 - trial;
                sroot_reg <= {sroot_reg[30:0], 1'b1};
            end
            else
            begin
                srem_reg  <= r2;
                sroot_reg <= {sroot_reg[30:0], 1'b0};
            end
        end
        if (cmd.den_load)
            den_reg <= (den_sum == '0) ? DIV_DEN_W'(1) : den_sum;
    end

    // Apply the step and saturate
    always_comb
    begin
        if (cap_reg || (quot[40:0] > UPD_CAP))
            upd = UPD_CAP;
        else
            upd = quot[40:0];
        cur_ext = 43'(cur_reg);
        upd_ext = $signed({2'b0, upd});
        res     = m_new_reg[31] ? (cur_ext + upd_ext) : (cur_ext - upd_ext);
        if (res > RES_MAX)
            res_sat = 32'sh7FFFFFFF;
        else if (res < RES_MIN)
            res_sat = 32'sh80000000;
        else
            res_sat = res[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            index_out     <= idx_reg;
            updated_value <= res_sat;
            step_done     <= eos_reg;
        end
    end

    assign status.clr_last = (clr_addr_reg == AW'(NUM_PARAMS - 1));
    assign status.upd_cap  = cap_reg;
    assign status.eos      = eos_reg;

endmodule

FILE: hdl/apu_ctrl.sv
// Controller: sequences the datapath through one parameter update
module apu_ctrl
    import apu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [5:0] RED_LAST  = 6'd9;
    localparam logic [5:0] MOM_LAST  = 6'd55;
    localparam logic [5:0] SQRT_LAST = 6'd31;
    localparam logic [5:0] UPD_LAST  = 6'd40;

    typedef enum logic [22:0] {
        S_CLEAR  = 23'h000001,
        S_IDLE   = 23'h000002,
        S_REDUCE = 23'h000004,
        S_READ   = 23'h000008,
        S_M1     = 23'h000010,
        S_M2     = 23'h000020,
        S_G2     = 23'h000040,
        S_V1     = 23'h000080,
        S_V2     = 23'h000100,
        S_VNEW   = 23'h000200,
        S_DIVM   = 23'h000400,
        S_LDV    = 23'h000800,
        S_DIVV   = 23'h001000,
        S_LDS    = 23'h002000,
        S_SQRT   = 23'h004000,
        S_PL     = 23'h008000,
        S_PH     = 23'h010000,
        S_LDU    = 23'h020000,
        S_DIVU   = 23'h040000,
        S_OUT    = 23'h080000,
        S_POW1   = 23'h100000,
        S_POW2   = 23'h200000,
        S_POW3   = 23'h400000
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       cnt_zero;
    logic       out_free;

    assign cnt_zero = (cnt_reg == '0);
    assign out_free = ~out_valid_reg | out_ready;

    // Next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_zero ? cnt_reg : cnt_reg - 1'b1;
        out_valid_next = out_valid_reg & ~out_ready;
        cmd            = '0;
        cmd.mul_sel    = MS_M1;
        cmd.div_load   = DL_NONE;
        cmd.red_shift  = cnt_reg[3:0];
        in_ready       = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (status.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    cnt_next    = RED_LAST;
                    state_next  = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                cmd.red_step = 1'b1;
                if (cnt_zero)
                    state_next = S_READ;
            end
            S_READ:
            begin
                cmd.mem_read = 1'b1;
                state_next   = S_M1;
            end
            S_M1:
            begin
                cmd.mul_sel = MS_M1;
                state_next  = S_M2;
            end
            S_M2:
            begin
                cmd.mul_sel  = MS_M2;
                cmd.acc_load = 1'b1;
                state_next   = S_G2;
            end
            S_G2:
            begin
                cmd.mul_sel  = MS_G2;
                cmd.m_update = 1'b1;
                state_next   = S_V1;
            end
            S_V1:
            begin
                cmd.mul_sel   = MS_V1;
                cmd.g2_update = 1'b1;
                state_next    = S_V2;
            end
            S_V2:
            begin
                cmd.mul_sel  = MS_V2;
                cmd.acc_load = 1'b1;
                state_next   = S_VNEW;
            end
            S_VNEW:
            begin
                cmd.v_update  = 1'b1;
                cmd.mem_write = 1'b1;
                cmd.div_load  = DL_MHAT;
                cnt_next      = MOM_LAST;
                state_next    = S_DIVM;
            end
            S_DIVM:
            begin
                cmd.div_step = 1'b1;
                if (cnt_zero)
                    state_next = S_LDV;
            end
            S_LDV:
            begin
                cmd.mhat_load = 1'b1;
                cmd.div_load  = DL_VHAT;
                cnt_next      = MOM_LAST;
                state_next    = S_DIVV;
            end
            S_DIVV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_zero)
                    state_next = S_LDS;
            end
            S_LDS:
            begin
                cmd.sqrt_load = 1'b1;
                cnt_next      = SQRT_LAST;
                state_next    = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (cnt_zero)
                    state_next = S_PL;
            end
            S_PL:
            begin
                cmd.den_load = 1'b1;
                cmd.mul_sel  = MS_PL;
                state_next   = S_PH;
            end
            S_PH:
            begin
                cmd.plo_load = 1'b1;
                cmd.mul_sel  = MS_PH;
                state_next   = S_LDU;
            end
            S_LDU:
            begin
                cmd.div_load = DL_UPD;
                cnt_next     = UPD_LAST;
                state_next   = S_DIVU;
            end
            S_DIVU:
            begin
                // Skip the division when the update already hits its cap
                cmd.div_step = ~status.upd_cap;
                if (cnt_zero || status.upd_cap)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = status.eos ? S_POW1 : S_IDLE;
                end
            end
            S_POW1:
            begin
                cmd.mul_sel = MS_P1;
                state_next  = S_POW2;
            end
            S_POW2:
            begin
                cmd.mul_sel   = MS_P2;
                cmd.p1_update = 1'b1;
                state_next    = S_POW3;
            end
            S_POW3:
            begin
                cmd.p2_update = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: hdl/adam_parameter_update.sv
// Adam optimizer parameter update: top level with configuration registers
//
// Usage: each transaction on param_ch carries one parameter (index, gradient,
// present value, end-of-step mark). The block updates that index's first and
// second moments, corrects both for bias and returns one transaction on
// result_ch with the index, the saturated new value and the end-of-step mark.
// The final division is skipped when the update hits its cap. The block takes
// one item at a time; an item marked end of step also advances the decay
// powers before the next item is taken. Most of the work is the 10-step
// index reduction, the one-bit-per-cycle divider (two 56-step bias
// corrections and a 41-step update division) and the 32-step root. After
// reset both moment stores are swept to the reset epsilon, one entry per
// cycle through all NUM_PARAMS entries, while param_ch.ready stays low; APB
// writes are taken throughout. A result held on a stalled result_ch does not
// block the next input; only the finishing step of that next item waits.
// Registers (APB, 24-bit values in 32-bit words, selected by paddr[3:2]):
// step_size, first_decay, second_decay, stabilizer. Writing a decay restarts
// its bias correction.
module adam_parameter_update
    import apu_pkg::*;
#(
    parameter int NUM_PARAMS = NUM_PARAMS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    apu_param_if.sink         param_ch,
    apu_result_if.source      result_ch
);

    cfg_t       cfg_reg;
    logic       cfg_write;
    logic [1:0] reg_sel;
    logic       p1_reload, p2_reload;
    cmd_t       cmd;
    status_t    status;

    // Configuration register file
    assign pready    = 1'b1;
    assign reg_sel   = paddr[3:2];
    assign cfg_write = psel & penable & pwrite & pready;
    assign p1_reload = cfg_write & (reg_sel == REG_FIRST_DECAY);
    assign p2_reload = cfg_write & (reg_sel == REG_SECOND_DECAY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_size    <= STEP_SIZE_RST;
            cfg_reg.first_decay  <= FIRST_DECAY_RST;
            cfg_reg.second_decay <= SECOND_DECAY_RST;
            cfg_reg.stabilizer   <= STABILIZER_RST;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_STEP_SIZE:    cfg_reg.step_size    <= pwdata[CFG_W-1:0];
                REG_FIRST_DECAY:  cfg_reg.first_decay  <= pwdata[CFG_W-1:0];
                REG_SECOND_DECAY: cfg_reg.second_decay <= pwdata[CFG_W-1:0];
                REG_STABILIZER:   cfg_reg.stabilizer   <= pwdata[CFG_W-1:0];
                default:          cfg_reg.stabilizer   <= cfg_reg.stabilizer;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (reg_sel)
            REG_STEP_SIZE:    prdata = 32'(cfg_reg.step_size);
            REG_FIRST_DECAY:  prdata = 32'(cfg_reg.first_decay);
            REG_SECOND_DECAY: prdata = 32'(cfg_reg.second_decay);
            REG_STABILIZER:   prdata = 32'(cfg_reg.stabilizer);
            default:          prdata = '0;
        endcase
    end

    apu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (param_ch.valid),
        .in_ready  (param_ch.ready),
        .out_valid (result_ch.valid),
        .out_ready (result_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    apu_dp #(
        .NUM_PARAMS (NUM_PARAMS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .p1_reload      (p1_reload),
        .p2_reload      (p2_reload),
        .reload_value   (pwdata[CFG_W-1:0]),
        .cmd            (cmd),
        .status         (status),
        .param_index    (param_ch.param_index),
        .gradient_value (param_ch.gradient_value),
        .current_value  (param_ch.current_value),
        .end_of_step    (param_ch.end_of_step),
        .index_out      (result_ch.index_out),
        .updated_value  (result_ch.updated_value),
        .step_done      (result_ch.step_done)
    );

    // Checks
`include "adam_parameter_update_assert.svh"

    `APU_ASSERT_NEXT(a_one_item_at_a_time, clk, rst_n,
        param_ch.valid && param_ch.ready, !param_ch.ready)
    `APU_ASSERT_IMPLY(a_result_after_work, clk, rst_n,
        $rose(result_ch.valid), $past(!param_ch.ready))

endmodule

FILE: tb/adam_update_checker.sv
// Checker for the Adam parameter update block: predicts each update and compares results
`timescale 1ns / 100ps
module adam_update_checker
    import apu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    apu_param_if              pch,
    apu_result_if             rch,
    output int                mismatches,
    output int                updates_pending
);
    localparam int DEPTH = NUM_PARAMS_DEF;
    localparam logic [63:0] ONE = 64'd1 << 24;
    localparam logic [63:0] HALF = 64'd1 << 23;
    localparam logic [63:0] CAP = 64'd1 << 40;

    typedef struct {
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] value;
        logic                    done;
    } update_t;

    // Mirrored registers and optimizer state
    logic [CFG_W-1:0]        lr, beta1, beta2, eps, beta1_pow, beta2_pow;
    logic signed [31:0]      first_mom [DEPTH];
    logic [31:0]             second_mom [DEPTH];
    update_t                 expected_updates [$];

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(longint x);
        if (x > longint'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
        if (x < -longint'(64'h80000000)) return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic logic [23:0] next_power(logic [23:0] p, logic [23:0] b);
        logic [63:0] prod;
        prod = (64'(p) * 64'(b) + HALF) >> 24;
        return prod[23:0];
    endfunction

    // Update moments for one parameter and return its new value
    function automatic logic signed [31:0] adam_step(logic [IDX_W-1:0] idx,
                                                      logic signed [31:0] g,
                                                      logic signed [31:0] cur);
        longint      gl, cl, macc, mnew, res;
        logic [63:0] mmag, gm, g2, vacc, vnew, mhat, vhat, root, den, upd;
        logic [127:0] q;
        logic        neg;
        int          s;
        s = int'(idx) % DEPTH;
        gl = longint'(g);
        cl = longint'(cur);
        // first moment, rounded half away from zero
        macc = longint'(beta1) * longint'(first_mom[s]) + longint'(ONE - 64'(beta1)) * gl;
        mmag = macc < 0 ? 64'(-macc) : 64'(macc);
        mmag = (mmag + HALF) >> 24;
        mnew = macc < 0 ? -longint'(mmag) : longint'(mmag);
        first_mom[s] = sat32(mnew);
        // second moment
        gm = gl < 0 ? 64'(-gl) : 64'(gl);
        g2 = (gm * gm + HALF) >> 24;
        if (g2 > 64'hFFFFFFFF) g2 = 64'hFFFFFFFF;
        vacc = 64'(beta2) * 64'(second_mom[s]) + (ONE - 64'(beta2)) * g2;
        vnew = (vacc + HALF) >> 24;
        if (vnew > 64'hFFFFFFFF) vnew = 64'hFFFFFFFF;
        second_mom[s] = vnew[31:0];
        // bias correction
        neg = first_mom[s] < 0;
        mmag = first_mom[s] < 0 ? 64'(-longint'(first_mom[s])) : 64'(first_mom[s]);
        mhat = (mmag << 24) / (ONE - 64'(beta1_pow));
        vhat = (64'(second_mom[s]) << 24) / (ONE - 64'(beta2_pow));
        if (vhat < CAP)
            root = int_sqrt(vhat << 24);
        else
            root = int_sqrt(vhat << 8) << 8;
        // zero denominator falls back to one LSB
        den = root + 64'(eps);
        if (den == 0) den = 1;
        q = (128'(mhat) * 128'(lr)) / 128'(den);
        upd = q > 128'(CAP) ? CAP : q[63:0];
        res = neg ? cl + longint'(upd) : cl - longint'(upd);
        return sat32(res);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        update_t e;
        update_t got;
        int      errs;
        errs = 0;
        if (!rst_n)
        begin
            lr <= STEP_SIZE_RST;
            beta1 <= FIRST_DECAY_RST;
            beta2 <= SECOND_DECAY_RST;
            eps <= STABILIZER_RST;
            beta1_pow <= FIRST_DECAY_RST;
            beta2_pow <= SECOND_DECAY_RST;
            for (int i = 0; i < DEPTH; i++)
            begin
                first_mom[i] = 32'(STABILIZER_RST);
                second_mom[i] = 32'(STABILIZER_RST);
            end
            expected_updates.delete();
            mismatches <= 0;
            updates_pending <= 0;
        end
        else
        begin
            // compare the result transaction against the oldest expectation
            if (rch.valid && rch.ready)
            begin
                got.idx = rch.index_out;
                got.value = rch.updated_value;
                got.done = rch.step_done;
                if (expected_updates.size() == 0)
                begin
                    $error("unexpected result transaction index %0d", got.idx);
                    errs++;
                end
                else
                begin
                    e = expected_updates.pop_front();
                    if (got.idx !== e.idx)
                    begin
                        $error("index_out: expected %0d actual %0d", e.idx, got.idx);
                        errs++;
                    end
                    if (got.value !== e.value)
                    begin
                        $error("updated_value: expected %0d actual %0d", e.value, got.value);
                        errs++;
                    end
                    if (got.done !== e.done)
                    begin
                        $error("step_done: expected %0d actual %0d", e.done, got.done);
                        errs++;
                    end
                end
            end
            mismatches <= mismatches + errs;
            // predict the parameter transaction
            if (pch.valid && pch.ready)
            begin
                e.idx = pch.param_index;
                e.value = adam_step(pch.param_index, pch.gradient_value, pch.current_value);
                e.done = pch.end_of_step;
                expected_updates.push_back(e);
                if (pch.end_of_step)
                begin
                    beta1_pow <= next_power(beta1_pow, beta1);
                    beta2_pow <= next_power(beta2_pow, beta2);
                end
            end
            // track register writes; a decay write restarts its power
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_STEP_SIZE: lr <= pwdata[CFG_W-1:0];
                    REG_FIRST_DECAY:
                    begin
                        beta1 <= pwdata[CFG_W-1:0];
                        beta1_pow <= pwdata[CFG_W-1:0];
                    end
                    REG_SECOND_DECAY:
                    begin
                        beta2 <= pwdata[CFG_W-1:0];
                        beta2_pow <= pwdata[CFG_W-1:0];
                    end
                    REG_STABILIZER: eps <= pwdata[CFG_W-1:0];
                    default: ;
                endcase
            end
            updates_pending <= expected_updates.size();
        end
    end
endmodule

FILE: tb/tb_top.sv
// Top of the Adam parameter update testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module tb_top;
    import apu_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 250;
    localparam int RAND_PER_PHASE = 110;

    logic              clk;
    logic              rst_n;
    logic              psel, penable, pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    int                mismatches;
    int                updates_pending;
    int                results_taken;
    int                cycle_count;

    apu_param_if  pch ();
    apu_result_if rch ();

    adam_parameter_update dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .param_ch(pch), .result_ch(rch)
    );

    adam_update_checker checker_i (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .pready(pready), .paddr(paddr), .pwdata(pwdata), .pch(pch), .rch(rch),
        .mismatches(mismatches), .updates_pending(updates_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Drain results with random stalls and one long hold-off
    initial
    begin
        int  w;
        bit  held;
        held = 0;
        results_taken = 0;
        rch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (!held && results_taken >= 40)
            begin
                held = 1;
                rch.ready <= 1'b0;
                repeat (3000) @(posedge clk);
            end
            else if (w != 0)
            begin
                rch.ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            rch.ready <= 1'b1;
            do @(posedge clk); while (!(rch.valid && rch.ready));
            results_taken++;
        end
    end

    task automatic apb_write(input logic [1:0] reg_idx, input logic [CFG_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'({reg_idx, 2'b00});
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_param(input logic [IDX_W-1:0] idx, input logic [31:0] grad,
                              input logic [31:0] cur, input logic eos);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            pch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pch.valid <= 1'b1;
        pch.param_index <= idx;
        pch.gradient_value <= grad;
        pch.current_value <= cur;
        pch.end_of_step <= eos;
        do @(posedge clk); while (!(pch.valid && pch.ready));
    endtask

    function automatic logic [31:0] rand_q24();
        case ($urandom_range(0, 9))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'h0;
            3, 4, 5, 6: return 32'($signed($urandom_range(0, 32'h03FFFFFF)) - 32'sh02000000);
            default: return $urandom();
        endcase
    endfunction

    // Wait until every update has come back and the block has gone quiet
    task automatic wait_idle();
        pch.valid <= 1'b0;
        @(posedge clk);
        while (updates_pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(input int count);
        logic [IDX_W-1:0] idx;
        for (int i = 0; i < count; i++)
        begin
            idx = ($urandom_range(0, 2) == 0) ? IDX_W'($urandom_range(0, 7)) : IDX_W'($urandom());
            send_param(idx, rand_q24(), rand_q24(), $urandom_range(0, 11) == 0);
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] cfg [5][4];
        cfg[0] = '{24'd16777, 24'd15099494, 24'd16760438, 24'd1};
        cfg[1] = '{24'hFFFFFF, 24'd0, 24'd0, 24'd0};
        cfg[2] = '{24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
        cfg[3] = '{24'd1677721, 24'd14000000, 24'd16000000, 24'd256};
        cfg[4] = '{CFG_W'($urandom()), CFG_W'($urandom()), CFG_W'($urandom()),
                   CFG_W'($urandom_range(0, 4095))};
        rst_n = 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        pch.valid <= 1'b0;
        pch.param_index <= '0;
        pch.gradient_value <= '0;
        pch.current_value <= '0;
        pch.end_of_step <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes under reset settings
        send_param(10'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
        send_param(10'd1023, 32'h80000000, 32'h80000000, 1'b0);
        send_param(10'd0, 32'h80000000, 32'h7FFFFFFF, 1'b0);
        send_param(10'd1023, 32'h7FFFFFFF, 32'h80000000, 1'b1);
        send_param(10'd5, 32'h0, 32'h0, 1'b0);
        send_param(10'd5, 32'h01000000, 32'hFFFFFFFF, 1'b0);
        send_param(10'd5, 32'hFF000000, 32'h01000000, 1'b1);
        send_param(10'h155, 32'h55555555, 32'hAAAAAAAA, 1'b0);
        send_param(10'h2AA, 32'hAAAAAAAA, 32'h55555555, 1'b1);
        send_param(10'd6, 32'h00000001, 32'h00000000, 1'b0);

        // hold stimulus until the block is idle, then sweep settings
        for (int p = 0; p < 5; p++)
        begin
            wait_idle();
            apb_write(REG_STEP_SIZE, cfg[p][0]);
            apb_write(REG_FIRST_DECAY, cfg[p][1]);
            apb_write(REG_SECOND_DECAY, cfg[p][2]);
            apb_write(REG_STABILIZER, cfg[p][3]);
            // zero gradient on a fresh entry; hits the zero denominator when eps is 0
            send_param(10'd900 + 10'(p), 32'h0, 32'h00800000, 1'b0);
            send_param(10'd900 + 10'(p), 32'h0, 32'h00800000, 1'b0);
            run_random(RAND_PER_PHASE);
        end

        wait_idle();
        if (mismatches == 0 && updates_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

FILE: adam_parameter_update.f
+incdir+hdl
hdl/apu_pkg.sv
hdl/apu_param_if.sv
hdl/apu_result_if.sv
hdl/apu_div.sv
hdl/apu_dp.sv
hdl/apu_ctrl.sv
hdl/adam_parameter_update.sv
tb/adam_update_checker.sv
tb/tb_top.sv
